>>> rtl/core/tcbd_pkg.sv
// Shared types, field codes and helpers for the trunk control burst decoder.
// Used by tcbd_ctrl, tcbd_dp and trunk_control_burst_decoder_core; no dependencies.
`default_nettype none

package tcbd_pkg;

	// call table depth; must be a power of two (slot = low bits of the call number)
	localparam int CALL_SLOTS = 16;
	localparam int SLOT_W     = $clog2(CALL_SLOTS);

	// configuration port
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 30;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQ = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPACING   = 4'd1;
	localparam logic [29:0] BASE_FREQ_RST = 30'd380000000;
	localparam logic [16:0] SPACING_RST   = 17'd25000;

	// logical channels
	localparam logic [3:0] CH_SYNC    = 4'd0;
	localparam logic [3:0] CH_NET     = 4'd1;
	localparam logic [3:0] CH_CTRL_A  = 4'd2;
	localparam logic [3:0] CH_CTRL_B  = 4'd3;
	localparam logic [3:0] CH_CTRL_C  = 4'd4;
	localparam logic [3:0] CH_CTRL_D  = 4'd5;
	localparam logic [3:0] CH_TRAFFIC = 4'd6;
	localparam logic [3:0] CH_STEAL   = 4'd7;

	// pdu ids
	localparam logic [7:0] PDU_SYSINFO = 8'h01;
	localparam logic [7:0] PDU_GRANT   = 8'h02;
	localparam logic [7:0] PDU_RELEASE = 8'h04;
	localparam logic [7:0] PDU_SDS     = 8'h05;
	localparam logic [7:0] TRF_SDS     = 8'h01;

	// grant type field
	localparam logic [3:0] GT_GROUP   = 4'd0;
	localparam logic [3:0] GT_PRIVATE = 4'd1;
	localparam logic [3:0] GT_EMERG   = 4'd4;
	localparam logic [1:0] CT_GROUP   = 2'd0;
	localparam logic [1:0] CT_PRIVATE = 2'd1;
	localparam logic [1:0] CT_EMERG   = 2'd2;
	localparam logic [1:0] CT_UNKNOWN = 2'd3;

	// minimum lengths
	localparam logic [8:0] LEN_SYNC    = 9'd60;
	localparam logic [8:0] LEN_FULL    = 9'd80;
	localparam logic [8:0] LEN_CTRL    = 9'd16;
	localparam logic [8:0] LEN_RELEASE = 9'd32;
	localparam logic [8:0] LEN_TRAFFIC = 9'd10;

	// emergency country range
	localparam logic [9:0] EMERG_LO = 10'd200;
	localparam logic [9:0] EMERG_HI = 10'd799;

	// result events
	localparam logic [3:0] EV_DROP      = 4'd0;
	localparam logic [3:0] EV_SYNC      = 4'd1;
	localparam logic [3:0] EV_NET       = 4'd2;
	localparam logic [3:0] EV_SYSINFO   = 4'd3;
	localparam logic [3:0] EV_GRANT     = 4'd4;
	localparam logic [3:0] EV_REL_HIT   = 4'd5;
	localparam logic [3:0] EV_REL_MISS  = 4'd6;
	localparam logic [3:0] EV_SHORT     = 4'd7;
	localparam logic [3:0] EV_VOICE     = 4'd8;
	localparam logic [3:0] EV_UNKNOWN   = 4'd9;

	localparam logic [1:0] CIPH_EXT = 2'd3;

	typedef struct packed {
		logic        crc_ok;
		logic [3:0]  channel;
		logic [63:0] bits_head;
		logic [15:0] bits_tail;
		logic [8:0]  length_bits;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]  event_res;
		logic [1:0]  call_type;
		logic [23:0] talkgroup;
		logic [23:0] source_unit;
		logic [30:0] frequency_hz;
		logic [2:0]  cipher_class;
		logic [23:0] call_number;
		logic [9:0]  country_code;
		logic [13:0] network_code;
		logic [1:0]  colour;
		logic        emergency_system;
		logic [15:0] area_id;
	} out_beat_t;

	// controller commands to the datapath
	typedef struct packed {
		logic capture;  // latch the accepted input beat
		logic exec;     // table read and channel multiply
		logic commit;   // update state and load the result register
	} cmd_t;

	// 2+2 bit cipher field to class
	function automatic logic [2:0] cipher_decode(input logic [1:0] c, input logic [1:0] ext);
		logic [2:0] r;
		if (c == CIPH_EXT) begin
			r = (ext == 2'd0) ? 3'd3 : 3'd4;
		end else begin
			r = {1'b0, c};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/tcbd_ctrl.sv
// Controller state machine of the burst decoder: input handshake, sequencing, output valid.
// Depends on tcbd_pkg.
`default_nettype none

module tcbd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output tcbd_pkg::cmd_t     cmd
);
	import tcbd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	// result register can take a new beat this cycle
	assign out_free = !out_valid_q || !out_stall;

	// next beat may enter while the current one commits
	assign in_stall = !((state_q == ST_IDLE) || (state_q == ST_FIN && out_free));
	assign accept   = in_valid && !in_stall;

	assign cmd.capture = accept;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.commit  = (state_q == ST_FIN) && out_free;
	assign out_valid   = out_valid_q;

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= accept ? ST_EXEC : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sequencing checks
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted beat did not start execution");
	a_exec_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q == ST_FIN)
		else $error("execute step not followed by finish");
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not raise output valid");
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("output valid rose outside finish");

endmodule

`default_nettype wire

>>> rtl/core/tcbd_dp.sv
// Datapath of the burst decoder: input register, config, site registers, call table,
// channel multiplier and result register. Depends on tcbd_pkg.
`default_nettype none

module tcbd_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tcbd_pkg::cmd_t                cmd,
	input  wire tcbd_pkg::in_beat_t            in_beat,
	input  wire logic                          cfg_we,
	input  wire logic [tcbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tcbd_pkg::CFG_DAT_W-1:0] cfg_data,
	output tcbd_pkg::out_beat_t                out_beat
);
	import tcbd_pkg::*;

	in_beat_t    in_q;
	out_beat_t   out_q;
	out_beat_t   res;
	logic [79:0] burst;

	logic [29:0] base_q;
	logic [16:0] spacing_q;
	logic [28:0] prod_q;

	logic [9:0]  country_q;
	logic [13:0] network_q;
	logic [1:0]  colour_q;
	logic        emergency_q;
	logic [15:0] area_q;
	logic        have_sync_q;
	logic [23:0] next_call_q;
	logic [31:0] ciphered_q;
	logic [31:0] clear_q;

	logic [CALL_SLOTS-1:0] slot_vld_q;
	logic [23:0]           num_mem [CALL_SLOTS];
	logic [23:0]           grp_mem [CALL_SLOTS];
	logic [23:0]           rd_num_q;
	logic [23:0]           rd_grp_q;
	logic                  rd_vld_q;

	logic [7:0]        pdu;
	logic [23:0]       rel_num;
	logic [SLOT_W-1:0] rel_slot;
	logic [SLOT_W-1:0] new_slot;
	logic [2:0]        grant_cc;
	logic [9:0]        sync_country;
	logic              do_sync, do_net, do_grant, do_hit;

	// bit 0 of the burst sits at the top
	assign burst    = {in_q.bits_head, in_q.bits_tail};
	assign pdu      = burst[79:72];
	assign rel_num  = burst[71:48];
	assign rel_slot = rel_num[SLOT_W-1:0];
	assign new_slot = next_call_q[SLOT_W-1:0];
	assign grant_cc = cipher_decode(burst[7:6], burst[5:4]);
	assign sync_country = burst[79:70];

	// input register
	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= in_beat;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= BASE_FREQ_RST;
			spacing_q <= SPACING_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_BASE_FREQ) base_q <= cfg_data;
			if (cfg_index == REG_SPACING)   spacing_q <= cfg_data[16:0];
		end
	end

	// execute step: channel index times spacing, call table read
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			prod_q   <= {17'b0, burst[19:8]} * {12'b0, spacing_q};
			rd_num_q <= num_mem[rel_slot];
			rd_grp_q <= grp_mem[rel_slot];
			rd_vld_q <= slot_vld_q[rel_slot];
		end
	end

	// burst decode and result
	always_comb begin
		res      = '0;
		do_sync  = 1'b0;
		do_net   = 1'b0;
		do_grant = 1'b0;
		do_hit   = 1'b0;
		if (in_q.crc_ok) begin
			unique case (in_q.channel)
				CH_SYNC: begin
					if (in_q.length_bits >= LEN_SYNC) begin
						do_sync              = 1'b1;
						res.event_res        = EV_SYNC;
						res.country_code     = sync_country;
						res.network_code     = burst[69:56];
						res.colour           = burst[51:50];
						res.emergency_system = (sync_country >= EMERG_LO)
							&& (sync_country <= EMERG_HI);
					end
				end
				CH_NET: begin
					if (in_q.length_bits >= LEN_FULL) begin
						do_net        = 1'b1;
						res.event_res = EV_NET;
						res.area_id   = burst[79:64];
					end
				end
				CH_CTRL_A, CH_CTRL_B, CH_CTRL_C, CH_CTRL_D: begin
					if (in_q.length_bits >= LEN_CTRL) begin
						unique case (pdu)
							PDU_SYSINFO: res.event_res = EV_SYSINFO;
							PDU_GRANT: begin
								if (in_q.length_bits >= LEN_FULL) begin
									do_grant         = 1'b1;
									res.event_res    = EV_GRANT;
									unique case (burst[71:68])
										GT_GROUP:   res.call_type = CT_GROUP;
										GT_PRIVATE: res.call_type = CT_PRIVATE;
										GT_EMERG:   res.call_type = CT_EMERG;
										default:    res.call_type = CT_UNKNOWN;
									endcase
									res.talkgroup    = burst[67:44];
									res.source_unit  = burst[43:20];
									res.frequency_hz = {1'b0, base_q} + {2'b0, prod_q};
									res.cipher_class = grant_cc;
									res.call_number  = next_call_q;
								end
							end
							PDU_RELEASE: begin
								if (in_q.length_bits >= LEN_RELEASE) begin
									res.call_number = rel_num;
									if (rd_vld_q && rd_num_q == rel_num) begin
										do_hit        = 1'b1;
										res.event_res = EV_REL_HIT;
										res.talkgroup = rd_grp_q;
									end else begin
										res.event_res = EV_REL_MISS;
									end
								end
							end
							PDU_SDS: begin
								if (in_q.length_bits >= LEN_RELEASE) res.event_res = EV_SHORT;
							end
							default: res.event_res = EV_UNKNOWN;
						endcase
					end
				end
				CH_TRAFFIC, CH_STEAL: begin
					if (in_q.length_bits >= LEN_TRAFFIC) begin
						if (pdu == TRF_SDS) begin
							if (in_q.length_bits >= LEN_RELEASE) res.event_res = EV_SHORT;
						end else begin
							res.event_res    = EV_VOICE;
							res.cipher_class = cipher_decode(burst[79:78], burst[77:76]);
						end
					end
				end
				default: res.event_res = EV_DROP;
			endcase
		end
	end

	// site and call state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			country_q   <= '0;
			network_q   <= '0;
			colour_q    <= '0;
			emergency_q <= 1'b0;
			area_q      <= '0;
			have_sync_q <= 1'b0;
			next_call_q <= '0;
			ciphered_q  <= '0;
			clear_q     <= '0;
			slot_vld_q  <= '0;
		end else if (cmd.commit) begin
			if (do_sync) begin
				country_q   <= res.country_code;
				network_q   <= res.network_code;
				colour_q    <= res.colour;
				emergency_q <= res.emergency_system;
				have_sync_q <= 1'b1;
			end
			if (do_net) area_q <= res.area_id;
			if (do_grant) begin
				slot_vld_q[new_slot] <= 1'b1;
				next_call_q          <= next_call_q + 24'd1;
				if (grant_cc != 3'd0) ciphered_q <= ciphered_q + 32'd1;
				else                  clear_q    <= clear_q + 32'd1;
			end
			if (do_hit) slot_vld_q[rel_slot] <= 1'b0;
		end
	end

	// call table write
	always_ff @(posedge clk) begin
		if (cmd.commit && do_grant) begin
			num_mem[new_slot] <= next_call_q;
			grp_mem[new_slot] <= res.talkgroup;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) out_q <= res;
	end

	assign out_beat = out_q;

endmodule

`default_nettype wire

>>> rtl/core/trunk_control_burst_decoder_core.sv
// Top level of the trunk control burst decoder: controller plus datapath.
// Depends on tcbd_pkg, tcbd_ctrl and tcbd_dp.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------
//  in      | in_valid/in_stall  | in_beat (tcbd_pkg::in_beat_t)
//  out     | out_valid/out_stall| out_beat (tcbd_pkg::out_beat_t)
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A burst is captured at its accepting edge, then passes the execute state (table read
// and channel multiply) and the finish state, whose commit loads the result register;
// the commit step overlaps the next accept, so a new beat can enter while one commits.
// Reset clears the site registers, call counter and slot valid bits; no clearing pass.
// A stalled result holds the commit step, and with it the input, until taken.
`default_nettype none

module trunk_control_burst_decoder_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire tcbd_pkg::in_beat_t             in_beat,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output tcbd_pkg::out_beat_t                 out_beat,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tcbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tcbd_pkg::CFG_DAT_W-1:0] cfg_data
);
	import tcbd_pkg::*;

	cmd_t cmd;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	tcbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tcbd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_beat   (in_beat),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_beat  (out_beat)
	);

endmodule

`default_nettype wire
